[rtl/rssd_pkg.sv]
// Shared types, codes and constants of the sprite span decoder.
package rssd_pkg;

  // Command byte codes and range limits
  localparam logic [7:0] CMD_ROW     = 8'h00;
  localparam logic [7:0] CMD_LIT_MAX = 8'h7F;
  localparam logic [7:0] CMD_END     = 8'h80;
  localparam logic [7:0] CMD_SKP_MAX = 8'hBF;
  localparam logic [7:0] CMD_SHADOW  = 8'hC0;
  localparam logic [7:0] CMD_FILL    = 8'hC1;

  // Mask that gives the shadow count from its alpha byte (alpha mod 4)
  localparam logic [7:0] SHADOW_CNT_MASK = 8'(4 - 1);

  // Span kinds
  localparam logic KIND_OPAQUE = 1'b0;
  localparam logic KIND_SHADOW = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SURFACE_HEIGHT = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_INDEX      = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_SUBSTITUTE = 4'd3;

  // Configuration reset values
  localparam logic [15:0] RST_SURFACE_WIDTH  = 16'd640;
  localparam logic [15:0] RST_SURFACE_HEIGHT = 16'd480;
  localparam logic [7:0]  RST_KEY_INDEX      = 8'd0;
  localparam logic [7:0]  RST_KEY_SUBSTITUTE = 8'd0;

  // Default depth of the queue between parser and span engine
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Parser phase
  typedef enum logic [2:0] {
    PH_CMD,
    PH_LITERAL,
    PH_SHADOW_ALPHA,
    PH_SHADOW_COUNT,
    PH_FILL_COUNT,
    PH_FILL_COLOUR
  } phase_t;

  // End cause of a sprite
  typedef enum logic [1:0] {
    DONE_RUN  = 2'd0,
    DONE_MARK = 2'd1,
    DONE_OUT  = 2'd2
  } done_t;

  // Operation handed from the parser to the span engine
  typedef enum logic [1:0] {
    OP_ROW,
    OP_SKIP,
    OP_SPAN,
    OP_END
  } op_code_t;

  typedef struct packed {
    op_code_t   code;
    logic [7:0] len;     // span length or skip distance
    logic       kind;
    logic [7:0] value;   // raw colour index or alpha
    done_t      done;
    logic       shadow;  // shadow seen, valid with a nonzero done
  } op_t;

  // Live configuration
  typedef struct packed {
    logic [15:0] surface_width;
    logic [15:0] surface_height;
    logic [7:0]  key_index;
    logic [7:0]  key_substitute;
  } cfg_t;

endpackage

[rtl/rssd_if.sv]
// Channel interfaces of the sprite span decoder: coded bytes, spans, configuration.
interface rssd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rssd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] span_x;
  logic [15:0] span_y;
  logic [7:0]  span_length;
  logic        span_kind;
  logic [7:0]  span_value;
  logic [1:0]  sprite_done;
  logic        shadow_seen;

  modport source (output valid, output span_x, output span_y, output span_length,
                  output span_kind, output span_value, output sprite_done,
                  output shadow_seen, input ready);
  modport sink   (input valid, input span_x, input span_y, input span_length,
                  input span_kind, input span_value, input sprite_done,
                  input shadow_seen, output ready);
endinterface

interface rssd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/rssd_front.sv]
// Byte parser: tracks the command phase and turns bytes into span operations.
module rssd_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             op_push,
  output rssd_pkg::op_t    op
);
  import rssd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] count_r, count_nxt;
  logic [7:0] alpha_r, alpha_nxt;
  logic       shadow_r, shadow_nxt;
  done_t      done;
  logic       shadow_hit;
  logic [7:0] count_dec;

  assign count_dec = count_r - 8'd1;

  // Classify end cause and shadow spans of this byte
  always_comb begin
    done = DONE_RUN;
    if (phase_r == PH_CMD && data_byte == CMD_END) begin
      done = DONE_MARK;
    end else if (last_byte) begin
      done = DONE_OUT;
    end
    shadow_hit = ((phase_r == PH_SHADOW_ALPHA) && ((data_byte & SHADOW_CNT_MASK) != 8'd0)) ||
                 ((phase_r == PH_SHADOW_COUNT) && (data_byte != 8'd0));
  end

  // Next state
  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    alpha_nxt  = alpha_r;
    shadow_nxt = shadow_r | shadow_hit;
    case (phase_r)
      PH_LITERAL: begin
        count_nxt = count_dec;
        if (count_dec == 8'd0) phase_nxt = PH_CMD;
      end
      PH_SHADOW_ALPHA: begin
        alpha_nxt = data_byte;
        phase_nxt = ((data_byte & SHADOW_CNT_MASK) != 8'd0) ? PH_CMD : PH_SHADOW_COUNT;
      end
      PH_SHADOW_COUNT: phase_nxt = PH_CMD;
      PH_FILL_COUNT: begin
        count_nxt = data_byte;
        phase_nxt = PH_FILL_COLOUR;
      end
      PH_FILL_COLOUR: begin
        count_nxt = 8'd0;
        phase_nxt = PH_CMD;
      end
      default: begin
        phase_nxt = PH_CMD;
        if (data_byte == CMD_ROW || data_byte == CMD_END) begin
          phase_nxt = PH_CMD;
        end else if (data_byte <= CMD_LIT_MAX) begin
          count_nxt = data_byte;
          phase_nxt = PH_LITERAL;
        end else if (data_byte <= CMD_SKP_MAX) begin
          phase_nxt = PH_CMD;
        end else if (data_byte == CMD_SHADOW) begin
          phase_nxt = PH_SHADOW_ALPHA;
        end else if (data_byte == CMD_FILL) begin
          phase_nxt = PH_FILL_COUNT;
        end else begin
          count_nxt = data_byte - CMD_SHADOW;
          phase_nxt = PH_FILL_COLOUR;
        end
      end
    endcase
    // Drop all sprite state once it ends
    if (done != DONE_RUN) begin
      phase_nxt  = PH_CMD;
      count_nxt  = 8'd0;
      alpha_nxt  = 8'd0;
      shadow_nxt = 1'b0;
    end
  end

  // Operation for the span engine
  always_comb begin
    logic has_op;
    has_op    = 1'b0;
    op        = '0;
    op.code   = OP_END;
    op.done   = done;
    op.shadow = shadow_r | shadow_hit;
    case (phase_r)
      PH_LITERAL: begin
        has_op   = 1'b1;
        op.code  = OP_SPAN;
        op.len   = 8'd1;
        op.kind  = KIND_OPAQUE;
        op.value = data_byte;
      end
      PH_SHADOW_ALPHA: begin
        has_op   = shadow_hit;
        op.code  = OP_SPAN;
        op.len   = data_byte & SHADOW_CNT_MASK;
        op.kind  = KIND_SHADOW;
        op.value = data_byte;
      end
      PH_SHADOW_COUNT: begin
        has_op   = shadow_hit;
        op.code  = OP_SPAN;
        op.len   = data_byte;
        op.kind  = KIND_SHADOW;
        op.value = alpha_r;
      end
      PH_FILL_COUNT: has_op = 1'b0;
      PH_FILL_COLOUR: begin
        has_op   = (count_r != 8'd0);
        op.code  = OP_SPAN;
        op.len   = count_r;
        op.kind  = KIND_OPAQUE;
        op.value = data_byte;
      end
      default: begin
        if (data_byte == CMD_ROW) begin
          has_op  = 1'b1;
          op.code = OP_ROW;
        end else if (data_byte > CMD_END && data_byte <= CMD_SKP_MAX) begin
          has_op  = 1'b1;
          op.code = OP_SKIP;
          op.len  = data_byte - CMD_END;
        end
      end
    endcase
    // An ending byte always yields one item; only a span survives next to the end
    if (done != DONE_RUN && !(has_op && op.code == OP_SPAN)) begin
      op.code  = OP_END;
      op.len   = 8'd0;
      op.kind  = KIND_OPAQUE;
      op.value = 8'd0;
    end
    op_push = accept && (has_op || done != DONE_RUN);
  end

  // Hold phase and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_CMD;
      count_r  <= 8'd0;
      alpha_r  <= 8'd0;
      shadow_r <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      alpha_r  <= alpha_nxt;
      shadow_r <= shadow_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op_push && op.done != DONE_RUN) |=> (phase_r == PH_CMD && !shadow_r))
    else $error("phase not cleared after sprite end");
  a_shadow_marks_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && shadow_hit && done == DONE_RUN) |=> shadow_r)
    else $error("shadow flag lost");
  a_span_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (op_push && op.code == OP_SPAN) |-> (op.len != 8'd0))
    else $error("empty span pushed");
`endif

endmodule

[rtl/rssd_queue.sv]
// Short operation queue between the parser and the span engine.
module rssd_queue #(
  parameter int unsigned DEPTH = rssd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rssd_pkg::op_t   push_op,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output rssd_pkg::op_t   pop_op
);
  import rssd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  op_t           slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_op    = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed operations
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_op;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance");
`endif

endmodule

[rtl/rssd_back.sv]
// Span engine: tracks column and row, clips spans, applies the colour key.
module rssd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  rssd_pkg::cfg_t  cfg,
  input  logic            op_valid,
  input  rssd_pkg::op_t   op,
  output logic            op_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     span_x,
  output logic [15:0]     span_y,
  output logic [7:0]      span_length,
  output logic            span_kind,
  output logic [7:0]      span_value,
  output logic [1:0]      sprite_done,
  output logic            shadow_seen
);
  import rssd_pkg::*;

  logic [15:0] column_r, column_nxt;
  logic [15:0] row_r, row_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] x_r, y_r;
  logic [7:0]  len_r, val_r;
  logic        kind_r, seen_r;
  done_t       done_r;

  logic        in_area, emit;
  logic [15:0] room;
  logic [7:0]  vis, value_k;

  // Clip against the surface and apply the key
  always_comb begin
    in_area = (column_r < cfg.surface_width) && (row_r < cfg.surface_height);
    room    = cfg.surface_width - column_r;
    vis     = ({8'd0, op.len} < room) ? op.len : room[7:0];
    value_k = (op.kind == KIND_OPAQUE && op.value == cfg.key_index) ?
              cfg.key_substitute : op.value;
  end

  assign op_pop = op_valid && (!valid_r || out_ready);
  assign emit   = op_pop && ((op.code == OP_SPAN && in_area) || op.done != DONE_RUN);

  // Advance position
  always_comb begin
    column_nxt = column_r;
    row_nxt    = row_r;
    if (op_pop) begin
      case (op.code)
        OP_ROW: begin
          row_nxt    = row_r + 16'd1;
          column_nxt = 16'd0;
        end
        OP_SKIP: column_nxt = column_r + {8'd0, op.len};
        OP_SPAN: column_nxt = column_r + {8'd0, op.len};
        default: column_nxt = column_r;
      endcase
      if (op.done != DONE_RUN) begin
        column_nxt = 16'd0;
        row_nxt    = 16'd0;
      end
    end
    valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= 16'd0;
      row_r    <= 16'd0;
      valid_r  <= 1'b0;
    end else begin
      column_r <= column_nxt;
      row_r    <= row_nxt;
      valid_r  <= valid_nxt;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (emit) begin
      if (op.code == OP_SPAN && in_area) begin
        x_r    <= column_r;
        y_r    <= row_r;
        len_r  <= vis;
        kind_r <= op.kind;
        val_r  <= value_k;
      end else begin
        x_r    <= 16'd0;
        y_r    <= 16'd0;
        len_r  <= 8'd0;
        kind_r <= KIND_OPAQUE;
        val_r  <= 8'd0;
      end
      done_r <= op.done;
      seen_r <= (op.done != DONE_RUN) && op.shadow;
    end
  end

  assign out_valid   = valid_r;
  assign span_x      = x_r;
  assign span_y      = y_r;
  assign span_length = len_r;
  assign span_kind   = kind_r;
  assign span_value  = val_r;
  assign sprite_done = done_r;
  assign shadow_seen = seen_r;

`ifndef SYNTHESIS
  a_running_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && done_r == DONE_RUN) |-> (len_r != 8'd0 && !seen_r))
    else $error("running item without visible pixels");
  a_end_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (op_pop && op.done != DONE_RUN) |=> (column_r == 16'd0 && row_r == 16'd0))
    else $error("position not cleared after sprite end");
  a_span_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && len_r != 8'd0) |-> (x_r < cfg.surface_width && y_r < cfg.surface_height))
    else $error("visible span outside surface");
`endif

endmodule

[rtl/rle_sprite_span_decoder.sv]
// Top level of the run-length sprite span decoder.
//
// in_ch takes the coded sprite one byte per transaction (data_byte, last_byte).
// out_ch gives one span transaction per byte that draws visible pixels, and one
// per sprite end (0x80 marker or a byte flagged last_byte); an end item carries
// sprite_done and shadow_seen and zeros in the span fields if nothing was drawn.
// cfg_ch writes surface_width (0), surface_height (1), key_index (2) and
// key_substitute (3); it is always ready and is meant for idle periods.
// Throughput: one byte per cycle while the queue has room. A parser stage classifies
// each byte in the cycle it is accepted and writes any operation it yields into a
// QUEUE_DEPTH entry queue; unless out_ch stalls, the span engine retires one
// operation per cycle, loading spans and ends into the output register; a span is
// registered in the queue, then in the output register. If out_ch stalls, the output
// register holds its item, the queue fills and in_ch.ready drops once it is full.
// Reset (rst_n low at a clock edge) restores register defaults 640, 480, 0, 0,
// empties the queue and output register and starts a new sprite.
module rle_sprite_span_decoder #(
  parameter int unsigned QUEUE_DEPTH = rssd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rssd_in_if.sink     in_ch,
  rssd_out_if.source  out_ch,
  rssd_cfg_if.sink    cfg_ch
);
  import rssd_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  in_accept;
  logic  q_full, q_push, q_pop, q_valid;
  op_t   q_in_op, q_out_op;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SURFACE_WIDTH:  cfg_nxt.surface_width  = cfg_ch.data;
        CFG_SURFACE_HEIGHT: cfg_nxt.surface_height = cfg_ch.data;
        CFG_KEY_INDEX:      cfg_nxt.key_index      = cfg_ch.data[7:0];
        CFG_KEY_SUBSTITUTE: cfg_nxt.key_substitute = cfg_ch.data[7:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surface_width  <= RST_SURFACE_WIDTH;
      cfg_r.surface_height <= RST_SURFACE_HEIGHT;
      cfg_r.key_index      <= RST_KEY_INDEX;
      cfg_r.key_substitute <= RST_KEY_SUBSTITUTE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Accept a byte whenever the queue has room
  assign in_ch.ready = !q_full;
  assign in_accept   = in_ch.valid && !q_full;

  rssd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .op_push   (q_push),
    .op        (q_in_op)
  );

  rssd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (q_in_op),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_op    (q_out_op)
  );

  rssd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .op_valid    (q_valid),
    .op          (q_out_op),
    .op_pop      (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .span_x      (out_ch.span_x),
    .span_y      (out_ch.span_y),
    .span_length (out_ch.span_length),
    .span_kind   (out_ch.span_kind),
    .span_value  (out_ch.span_value),
    .sprite_done (out_ch.sprite_done),
    .shadow_seen (out_ch.shadow_seen)
  );

endmodule
